[hdl/bvc_pkg.sv]
// Shared types and constants for the button view controller.
// No dependencies; every other file imports this package.
package bvc_pkg;

  localparam int unsigned VIEW_TOTAL_DEF = 6;
  localparam int unsigned TIMER_BITS_DEF = 16;

  localparam int unsigned CFG_W     = 16;
  localparam int unsigned CFG_IDX_W = 8;
  localparam int unsigned VIEW_W    = 3;
  localparam int unsigned LEVEL_W   = 8;
  localparam int unsigned STEP_W    = 2;

  localparam logic [CFG_W-1:0]   LONG_PRESS_RST   = 16'd900;
  localparam logic [CFG_W-1:0]   TAP_MIN_RST      = 16'd30;
  localparam logic [CFG_W-1:0]   BRIGHT_LOCK_RST  = 16'd300;
  localparam logic [CFG_W-1:0]   AUTO_CYCLE_RST   = 16'd8000;
  localparam logic [LEVEL_W-1:0] INIT_BRIGHT_RST  = 8'd200;
  localparam logic [STEP_W-1:0]  BRIGHT_STEP_RST  = 2'd2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LONG_PRESS  = 8'd0,
    CFG_TAP_MIN     = 8'd1,
    CFG_BRIGHT_LOCK = 8'd2,
    CFG_AUTO_CYCLE  = 8'd3,
    CFG_INIT_BRIGHT = 8'd4
  } cfg_idx_e;

  typedef struct packed {
    logic [CFG_W-1:0]   long_press_ticks;
    logic [CFG_W-1:0]   tap_min_ticks;
    logic [CFG_W-1:0]   bright_lockout_ticks;
    logic [CFG_W-1:0]   auto_cycle_ticks;
    logic [LEVEL_W-1:0] initial_brightness;
  } cfg_t;

  typedef struct packed {
    logic [VIEW_W-1:0]  view_index;
    logic               auto_cycle_on;
    logic [LEVEL_W-1:0] backlight_level;
    logic               tap_seen;
    logic               long_seen;
    logic               view_changed;
  } res_t;

  function automatic logic [LEVEL_W-1:0] level_of(input logic [STEP_W-1:0] step);
    logic [LEVEL_W-1:0] lvl;
    case (step)
      2'd0:    lvl = 8'd60;
      2'd1:    lvl = 8'd120;
      2'd2:    lvl = 8'd200;
      default: lvl = 8'd255;
    endcase
    return lvl;
  endfunction

endpackage

[hdl/bvc_if.sv]
// Valid/ready channel interfaces: tick beats in, result beats out, register writes.
// Depends on bvc_pkg.
interface bvc_tick_if;
  logic valid;
  logic ready;
  logic view_button_down;
  logic bright_button_down;
  modport source (output valid, output view_button_down, output bright_button_down,
                  input ready);
  modport sink   (input valid, input view_button_down, input bright_button_down,
                  output ready);
endinterface

interface bvc_result_if
  import bvc_pkg::*;
;
  logic               valid;
  logic               ready;
  logic [VIEW_W-1:0]  view_index;
  logic               auto_cycle_on;
  logic [LEVEL_W-1:0] backlight_level;
  logic               tap_seen;
  logic               long_seen;
  logic               view_changed;
  modport source (output valid, output view_index, output auto_cycle_on,
                  output backlight_level, output tap_seen, output long_seen,
                  output view_changed, input ready);
  modport sink   (input valid, input view_index, input auto_cycle_on,
                  input backlight_level, input tap_seen, input long_seen,
                  input view_changed, output ready);
endinterface

interface bvc_cfg_if
  import bvc_pkg::*;
;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_W-1:0]     data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

[hdl/bvc_core.sv]
// Button state, timers and view/brightness update for one tick per accepted beat.
// Depends on bvc_pkg.
module bvc_core
  import bvc_pkg::*;
#(
  parameter int unsigned VIEW_TOTAL = VIEW_TOTAL_DEF,
  parameter int unsigned TIMER_BITS = TIMER_BITS_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic step_i,
  input  logic view_down_i,
  input  logic bright_down_i,
  input  cfg_t cfg_i,
  output res_t res_o
);

  localparam int unsigned CMP_W = (TIMER_BITS > CFG_W) ? TIMER_BITS : CFG_W;
  localparam logic [VIEW_W:0] VIEW_END = (VIEW_W+1)'(VIEW_TOTAL);

  logic                  was_down_q, was_down_d;
  logic [TIMER_BITS-1:0] held_q, held_d, held_inc;
  logic                  fired_q, fired_d;
  logic [TIMER_BITS-1:0] bright_cnt_q, bright_cnt_d, bright_inc;
  logic [STEP_W-1:0]     step_q, step_d;
  logic                  touched_q, touched_d;
  logic [VIEW_W-1:0]     view_q, view_d, view_tap;
  logic                  auto_en_q, auto_en_d;
  logic [TIMER_BITS-1:0] auto_cnt_q, auto_cnt_d, auto_inc, auto_mid;
  logic                  bright_ok, press_start, long_hit, tap_hit, auto_fire;

  function automatic logic [TIMER_BITS-1:0] sat_inc(input logic [TIMER_BITS-1:0] c);
    return (c == '1) ? c : c + 1'b1;
  endfunction

  function automatic logic [VIEW_W-1:0] next_view(input logic [VIEW_W-1:0] v);
    logic [VIEW_W:0] n;
    n = {1'b0, v} + 1'b1;
    return (n >= VIEW_END) ? '0 : n[VIEW_W-1:0];
  endfunction

  always_comb begin
    held_inc   = sat_inc(held_q);
    bright_inc = sat_inc(bright_cnt_q);
    auto_inc   = sat_inc(auto_cnt_q);

    bright_ok    = bright_down_i &&
                   (CMP_W'(bright_inc) > CMP_W'(cfg_i.bright_lockout_ticks));
    bright_cnt_d = bright_ok ? '0 : bright_inc;
    step_d       = bright_ok ? step_q + 1'b1 : step_q;
    touched_d    = touched_q | bright_ok;

    press_start = view_down_i && !was_down_q;
    long_hit    = view_down_i && was_down_q && !fired_q &&
                  (CMP_W'(held_inc) >= CMP_W'(cfg_i.long_press_ticks));
    tap_hit     = !view_down_i && was_down_q && !fired_q &&
                  (CMP_W'(held_inc) > CMP_W'(cfg_i.tap_min_ticks));
    was_down_d  = view_down_i;
    held_d      = press_start ? '0 : held_inc;
    fired_d     = press_start ? 1'b0 : (fired_q | long_hit);

    view_tap  = tap_hit ? next_view(view_q) : view_q;
    auto_mid  = (tap_hit || long_hit) ? '0 : auto_inc;
    auto_en_d = long_hit ? !auto_en_q : auto_en_q;
    auto_fire = auto_en_d && (CMP_W'(auto_mid) >= CMP_W'(cfg_i.auto_cycle_ticks));
    auto_cnt_d = auto_fire ? '0 : auto_mid;
    view_d     = auto_fire ? next_view(view_tap) : view_tap;

    res_o.view_index      = view_d;
    res_o.auto_cycle_on   = auto_en_d;
    res_o.backlight_level = touched_d ? level_of(step_d) : cfg_i.initial_brightness;
    res_o.tap_seen        = tap_hit;
    res_o.long_seen       = long_hit;
    res_o.view_changed    = (view_d != view_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      was_down_q   <= 1'b0;
      held_q       <= '0;
      fired_q      <= 1'b0;
      bright_cnt_q <= '0;
      step_q       <= BRIGHT_STEP_RST;
      touched_q    <= 1'b0;
      view_q       <= '0;
      auto_en_q    <= 1'b0;
      auto_cnt_q   <= '0;
    end else if (step_i) begin
      was_down_q   <= was_down_d;
      held_q       <= held_d;
      fired_q      <= fired_d;
      bright_cnt_q <= bright_cnt_d;
      step_q       <= step_d;
      touched_q    <= touched_d;
      view_q       <= view_d;
      auto_en_q    <= auto_en_d;
      auto_cnt_q   <= auto_cnt_d;
    end
  end

endmodule

[hdl/button_view_controller.sv]
// Top level of the button view controller: register file, tick handshake, result register.
// Depends on bvc_pkg, bvc_if and bvc_core.
//
// Each tick beat carries the two sampled button levels and yields exactly one result
// beat. The state update is combinational compares and saturating counter steps, so
// a tick is accepted every cycle while the one output result register is empty or
// being drained in the same cycle; a result appears in the cycle after its tick is
// taken. Register writes are always ready and take effect on the next tick; indexes
// beyond the register list are ignored.
module button_view_controller
  import bvc_pkg::*;
#(
  parameter int unsigned VIEW_TOTAL = VIEW_TOTAL_DEF,
  parameter int unsigned TIMER_BITS = TIMER_BITS_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  bvc_tick_if.sink     tick_i,
  bvc_result_if.source result_o,
  bvc_cfg_if.sink      cfg_i
);

  cfg_t cfg_q;
  res_t res_d, res_q;
  logic out_valid_q;
  logic tick_take;

  assign cfg_i.ready  = 1'b1;
  assign tick_i.ready = !out_valid_q || result_o.ready;
  assign tick_take    = tick_i.valid && tick_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.long_press_ticks     <= LONG_PRESS_RST;
      cfg_q.tap_min_ticks        <= TAP_MIN_RST;
      cfg_q.bright_lockout_ticks <= BRIGHT_LOCK_RST;
      cfg_q.auto_cycle_ticks     <= AUTO_CYCLE_RST;
      cfg_q.initial_brightness   <= INIT_BRIGHT_RST;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        CFG_LONG_PRESS:  cfg_q.long_press_ticks     <= cfg_i.data;
        CFG_TAP_MIN:     cfg_q.tap_min_ticks        <= cfg_i.data;
        CFG_BRIGHT_LOCK: cfg_q.bright_lockout_ticks <= cfg_i.data;
        CFG_AUTO_CYCLE:  cfg_q.auto_cycle_ticks     <= cfg_i.data;
        CFG_INIT_BRIGHT: cfg_q.initial_brightness   <= cfg_i.data[LEVEL_W-1:0];
        default: ;
      endcase
    end
  end

  bvc_core #(
    .VIEW_TOTAL (VIEW_TOTAL),
    .TIMER_BITS (TIMER_BITS)
  ) u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .step_i        (tick_take),
    .view_down_i   (tick_i.view_button_down),
    .bright_down_i (tick_i.bright_button_down),
    .cfg_i         (cfg_q),
    .res_o         (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (tick_i.ready) begin
      out_valid_q <= tick_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (tick_take) begin
      res_q <= res_d;
    end
  end

  assign result_o.valid           = out_valid_q;
  assign result_o.view_index      = res_q.view_index;
  assign result_o.auto_cycle_on   = res_q.auto_cycle_on;
  assign result_o.backlight_level = res_q.backlight_level;
  assign result_o.tap_seen        = res_q.tap_seen;
  assign result_o.long_seen       = res_q.long_seen;
  assign result_o.view_changed    = res_q.view_changed;

endmodule

[verif/testbench.sv]
// Self-checking testbench for button_view_controller: drives tick beats and register
// writes, predicts every result beat and compares it field by field.
// Depends on bvc_pkg, the bvc channel interfaces and the RTL of the block.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import bvc_pkg::*;

  localparam int unsigned RESET_CYCLES     = 4;
  localparam int unsigned MAX_GAP          = 13;
  localparam int unsigned STALL_LIMIT      = 3000;
  localparam int unsigned HOLD_OFF_CYCLES  = 200;
  localparam int unsigned SETTLE_CYCLES    = 4;
  localparam int unsigned RANDOM_PHASES    = 6;
  localparam int unsigned PHASE_TICKS      = 220;
  localparam int unsigned LONG_HOLD_TICKS  = 100;
  localparam int unsigned MAX_HOLD         = 80;
  localparam int unsigned MAX_REPORTS      = 40;
  localparam int unsigned IDX_TOP          = (1 << CFG_IDX_W) - 1;
  localparam int unsigned FIRST_UNUSED_IDX = CFG_INIT_BRIGHT + 1;
  localparam logic [4*LEVEL_W-1:0] BACKLIGHT_STEPS = {8'd255, 8'd200, 8'd120, 8'd60};

  class tick_scoreboard;
    cfg_t settings;
    bit view_was_down;
    bit long_fired;
    bit level_touched;
    bit auto_on;
    logic [TIMER_BITS_DEF-1:0] held_ticks;
    logic [TIMER_BITS_DEF-1:0] bright_ticks;
    logic [TIMER_BITS_DEF-1:0] auto_ticks;
    logic [STEP_W-1:0] level_step;
    logic [VIEW_W-1:0] view;
    res_t expected_q[$];
    int unsigned errors;
    int unsigned checked;

    function new();
      settings.long_press_ticks     = LONG_PRESS_RST;
      settings.tap_min_ticks        = TAP_MIN_RST;
      settings.bright_lockout_ticks = BRIGHT_LOCK_RST;
      settings.auto_cycle_ticks     = AUTO_CYCLE_RST;
      settings.initial_brightness   = INIT_BRIGHT_RST;
      view_was_down = 1'b0;
      long_fired    = 1'b0;
      level_touched = 1'b0;
      auto_on       = 1'b0;
      held_ticks    = '0;
      bright_ticks  = '0;
      auto_ticks    = '0;
      level_step    = BRIGHT_STEP_RST;
      view          = '0;
      errors        = 0;
      checked       = 0;
    endfunction

    function logic [TIMER_BITS_DEF-1:0] bump(logic [TIMER_BITS_DEF-1:0] c);
      return (&c) ? c : c + 1'b1;
    endfunction

    function logic [VIEW_W-1:0] advance(logic [VIEW_W-1:0] v);
      int unsigned n;
      n = v + 1;
      return (n >= VIEW_TOTAL_DEF) ? '0 : VIEW_W'(n);
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
      case (idx)
        CFG_LONG_PRESS:  settings.long_press_ticks     = data;
        CFG_TAP_MIN:     settings.tap_min_ticks        = data;
        CFG_BRIGHT_LOCK: settings.bright_lockout_ticks = data;
        CFG_AUTO_CYCLE:  settings.auto_cycle_ticks     = data;
        CFG_INIT_BRIGHT: settings.initial_brightness   = data[LEVEL_W-1:0];
        default: ;
      endcase
    endfunction

    function void note_tick(bit view_down, bit bright_down);
      res_t want;
      logic [VIEW_W-1:0] prev_view;
      bit tap;
      bit hold;
      prev_view = view;
      tap  = 1'b0;
      hold = 1'b0;
      held_ticks   = bump(held_ticks);
      bright_ticks = bump(bright_ticks);
      auto_ticks   = bump(auto_ticks);
      if (bright_down && bright_ticks > settings.bright_lockout_ticks) begin
        bright_ticks  = '0;
        level_step    = level_step + 1'b1;
        level_touched = 1'b1;
      end
      if (view_down && !view_was_down) begin
        view_was_down = 1'b1;
        held_ticks    = '0;
        long_fired    = 1'b0;
      end else if (view_down && !long_fired && held_ticks >= settings.long_press_ticks) begin
        long_fired = 1'b1;
        hold       = 1'b1;
      end else if (!view_down && view_was_down) begin
        view_was_down = 1'b0;
        tap = !long_fired && held_ticks > settings.tap_min_ticks;
      end
      if (tap) begin
        view       = advance(view);
        auto_ticks = '0;
      end else if (hold) begin
        auto_on    = !auto_on;
        auto_ticks = '0;
      end
      if (auto_on && auto_ticks >= settings.auto_cycle_ticks) begin
        auto_ticks = '0;
        view       = advance(view);
      end
      want.view_index      = view;
      want.auto_cycle_on   = auto_on;
      want.backlight_level = level_touched ? BACKLIGHT_STEPS[level_step*LEVEL_W +: LEVEL_W]
                                           : settings.initial_brightness;
      want.tap_seen        = tap;
      want.long_seen       = hold;
      want.view_changed    = view != prev_view;
      expected_q.push_back(want);
    endfunction

    task report(string what, logic [LEVEL_W-1:0] got, logic [LEVEL_W-1:0] want);
      errors++;
      if (errors <= MAX_REPORTS)
        $display("result beat %0d: %s is %0d, expected %0d", checked, what, got, want);
    endtask

    task check_result(res_t got);
      res_t want;
      checked++;
      if (expected_q.size() == 0) begin
        report("beat with nothing pending, view_index", LEVEL_W'(got.view_index), '0);
        return;
      end
      want = expected_q.pop_front();
      if (got.view_index !== want.view_index)
        report("view_index", LEVEL_W'(got.view_index), LEVEL_W'(want.view_index));
      if (got.auto_cycle_on !== want.auto_cycle_on)
        report("auto_cycle_on", LEVEL_W'(got.auto_cycle_on), LEVEL_W'(want.auto_cycle_on));
      if (got.backlight_level !== want.backlight_level)
        report("backlight_level", got.backlight_level, want.backlight_level);
      if (got.tap_seen !== want.tap_seen)
        report("tap_seen", LEVEL_W'(got.tap_seen), LEVEL_W'(want.tap_seen));
      if (got.long_seen !== want.long_seen)
        report("long_seen", LEVEL_W'(got.long_seen), LEVEL_W'(want.long_seen));
      if (got.view_changed !== want.view_changed)
        report("view_changed", LEVEL_W'(got.view_changed), LEVEL_W'(want.view_changed));
    endtask
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;
  bit send_idle;
  bit recv_idle;
  bit hold_off_req;
  int unsigned stall_cycles = 0;
  tick_scoreboard sb = new();

  bvc_tick_if   tick_if ();
  bvc_result_if res_if ();
  bvc_cfg_if    cfg_if ();

  button_view_controller DUT (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .tick_i   (tick_if),
    .result_o (res_if),
    .cfg_i    (cfg_if)
  );

  always #10ns clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if ((tick_if.valid && tick_if.ready) || (res_if.valid && res_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles + 1 >= STALL_LIMIT) begin
      $display("button_view_controller test failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  function automatic int unsigned draw_gap(bit idle);
    return idle ? $urandom_range(0, MAX_GAP) : 0;
  endfunction

  task automatic send_tick(bit view_down, bit bright_down);
    int unsigned gap;
    gap = draw_gap(send_idle);
    if (gap != 0) begin
      tick_if.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    tick_if.valid              <= 1'b1;
    tick_if.view_button_down   <= view_down;
    tick_if.bright_button_down <= bright_down;
    do @(posedge clk_i); while (!tick_if.ready);
    sb.note_tick(view_down, bright_down);
    @(negedge clk_i);
  endtask

  task automatic wait_idle();
    tick_if.valid <= 1'b0;
    do @(negedge clk_i); while (sb.expected_q.size() != 0);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= data;
    do @(posedge clk_i); while (!cfg_if.ready);
    sb.write_reg(idx, data);
    @(negedge clk_i);
  endtask

  task automatic write_all(logic [CFG_W-1:0] long_t, logic [CFG_W-1:0] tap_t,
                           logic [CFG_W-1:0] lock_t, logic [CFG_W-1:0] cycle_t,
                           logic [CFG_W-1:0] init_t);
    write_reg(CFG_LONG_PRESS, long_t);
    write_reg(CFG_TAP_MIN, tap_t);
    write_reg(CFG_BRIGHT_LOCK, lock_t);
    write_reg(CFG_AUTO_CYCLE, cycle_t);
    write_reg(CFG_INIT_BRIGHT, init_t);
    write_reg(CFG_IDX_W'($urandom_range(FIRST_UNUSED_IDX, IDX_TOP)), CFG_W'($urandom));
    cfg_if.valid <= 1'b0;
  endtask

  task automatic run_directed();
    send_idle = 1'b1;
    recv_idle = 1'b1;
    // reset settings: short press, brightness still locked out
    send_tick(1'b0, 1'b0);
    send_tick(1'b0, 1'b1);
    send_tick(1'b1, 1'b0);
    send_tick(1'b0, 1'b0);
    wait_idle();
    // zero periods: long fires the tick after press, auto advances every tick
    write_all(16'd0, 16'd0, 16'd0, 16'd0, 16'hA5C3);
    send_tick(1'b1, 1'b1);
    send_tick(1'b1, 1'b1);
    send_tick(1'b0, 1'b0);
    send_tick(1'b1, 1'b0);
    send_tick(1'b0, 1'b1);
    send_tick(1'b1, 1'b1);
    send_tick(1'b1, 1'b1);
    send_tick(1'b0, 1'b1);
    wait_idle();
    write_all(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd1, 16'h00FF);
    send_tick(1'b1, 1'b0);
    send_tick(1'b1, 1'b1);
    send_tick(1'b0, 1'b1);
    wait_idle();
    write_all(16'd3, 16'd1, 16'd1, 16'd2, 16'h0000);
    send_tick(1'b1, 1'b0);
    send_tick(1'b1, 1'b0);
    send_tick(1'b0, 1'b0);
    send_tick(1'b1, 1'b1);
    send_tick(1'b1, 1'b1);
    send_tick(1'b1, 1'b1);
    send_tick(1'b1, 1'b0);
    send_tick(1'b0, 1'b0);
    wait_idle();
  endtask

  task automatic run_max_thresholds();
    send_idle = 1'b0;
    recv_idle = 1'b0;
    // hold both buttons with the press, tap and lockout thresholds at their maximum
    write_all(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd8, 16'h0000);
    send_tick(1'b0, 1'b0);
    repeat (LONG_HOLD_TICKS) send_tick(1'b1, 1'b1);
    send_tick(1'b0, 1'b0);
    wait_idle();
    write_reg(CFG_BRIGHT_LOCK, 16'hFFFE);
    cfg_if.valid <= 1'b0;
    send_tick(1'b0, 1'b1);
    send_tick(1'b0, 1'b1);
    wait_idle();
  endtask

  task automatic run_random_phase(int unsigned phase);
    int unsigned sent;
    int unsigned pick;
    int unsigned rest_len;
    int hold_len;
    bit bright_run;
    bit pressure_done;
    logic [CFG_W-1:0] long_t;
    wait_idle();
    send_idle = $urandom_range(0, 3) != 0;
    recv_idle = $urandom_range(0, 3) != 0;
    long_t    = CFG_W'($urandom_range(2, 40));
    case (phase)
      0: write_all(16'd1, 16'd0, 16'd0, 16'd1, CFG_W'($urandom));
      1: begin
        send_idle = 1'b0;
        write_all(long_t, 16'hFFFF, CFG_W'($urandom_range(0, 25)),
                  CFG_W'($urandom_range(1, 60)), CFG_W'($urandom));
      end
      default: write_all(long_t, CFG_W'($urandom_range(0, long_t)),
                         CFG_W'($urandom_range(0, 25)), CFG_W'($urandom_range(1, 60)),
                         CFG_W'($urandom));
    endcase
    sent = 0;
    pressure_done = 1'b0;
    while (sent < PHASE_TICKS) begin
      if (!pressure_done && sent >= 40) begin
        pressure_done = 1'b1;
        if (phase == 1) hold_off_req = 1'b1;
        if (phase == 3) wait_idle();
      end
      pick = $urandom_range(0, 9);
      if (pick < 2) begin
        send_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        sent++;
      end else begin
        case (pick % 3)
          0:       hold_len = int'(sb.settings.tap_min_ticks) + $urandom_range(0, 2) - 1;
          1:       hold_len = int'(sb.settings.long_press_ticks) + $urandom_range(0, 3) - 1;
          default: hold_len = $urandom_range(1, 50);
        endcase
        if (hold_len < 1) hold_len = 1;
        if (hold_len > MAX_HOLD) hold_len = MAX_HOLD;
        rest_len   = $urandom_range(0, 6);
        bright_run = $urandom_range(0, 4) == 0;
        repeat (rest_len) send_tick(1'b0, bright_run || $urandom_range(0, 7) == 0);
        repeat (hold_len) send_tick(1'b1, bright_run || $urandom_range(0, 7) == 0);
        sent += rest_len + hold_len;
      end
    end
  endtask

  initial begin : result_side
    res_t got;
    int unsigned wait_len;
    res_if.ready = 1'b0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      wait_len = draw_gap(recv_idle);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        wait_len += HOLD_OFF_CYCLES;
      end
      if (wait_len != 0) begin
        res_if.ready <= 1'b0;
        repeat (wait_len) @(negedge clk_i);
      end
      res_if.ready <= 1'b1;
      do @(posedge clk_i); while (!res_if.valid);
      got.view_index      = res_if.view_index;
      got.auto_cycle_on   = res_if.auto_cycle_on;
      got.backlight_level = res_if.backlight_level;
      got.tap_seen        = res_if.tap_seen;
      got.long_seen       = res_if.long_seen;
      got.view_changed    = res_if.view_changed;
      sb.check_result(got);
      @(negedge clk_i);
    end
  end

  initial begin : stimulus
    int unsigned phase;
    rst_ni                     = 1'b0;
    tick_if.valid              = 1'b0;
    tick_if.view_button_down   = 1'b0;
    tick_if.bright_button_down = 1'b0;
    cfg_if.valid               = 1'b0;
    cfg_if.index               = '0;
    cfg_if.data                = '0;
    send_idle                  = 1'b0;
    recv_idle                  = 1'b0;
    hold_off_req               = 1'b0;
    repeat (RESET_CYCLES) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    run_directed();
    run_max_thresholds();
    for (phase = 0; phase < RANDOM_PHASES; phase++) run_random_phase(phase);
    wait_idle();
    repeat (SETTLE_CYCLES) @(negedge clk_i);
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("button_view_controller test passed");
    end else begin
      $display("button_view_controller test failed");
    end
    $finish;
  end

endmodule

[filelist.f]
hdl/bvc_pkg.sv
hdl/bvc_if.sv
hdl/bvc_core.sv
hdl/button_view_controller.sv
verif/testbench.sv
